[sv/frc_pkg.sv]
// Package for the six-plane frustum culling block: codes, widths and types.
// Used by every module of the block; depends on nothing.
package frc_pkg;

   // Action codes on the request channel
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_SPHERE = 2'd1;
   localparam logic [1:0] ACT_BOX    = 2'd2;

   localparam int NUM_PLANES    = 6;
   localparam int NUM_COEFFS    = NUM_PLANES * 4;
   localparam int COEFF_IDX_W   = 5;
   localparam int FRAC_BITS_DEF = 16;

   // Coefficient slot within a plane
   localparam logic [1:0] COEF_A = 2'd0;
   localparam logic [1:0] COEF_B = 2'd1;
   localparam logic [1:0] COEF_C = 2'd2;
   localparam logic [1:0] COEF_D = 2'd3;

   localparam int VAL_W  = 32;             // signed Q coordinates and coefficients
   localparam int EXT_W  = 31;             // unsigned radius and half extents
   localparam int OPND_W = VAL_W + 1;      // coordinate plus or minus half extent
   localparam int PROD_W = VAL_W + OPND_W; // coefficient times adjusted operand
   localparam int SUM_W  = PROD_W + 3;     // three products plus offset, no overflow

   typedef struct packed {
      logic signed [VAL_W-1:0] a;
      logic signed [VAL_W-1:0] b;
      logic signed [VAL_W-1:0] c;
      logic signed [VAL_W-1:0] d;
   } plane_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] px;
      logic signed [VAL_W-1:0] py;
      logic signed [VAL_W-1:0] pz;
      logic        [EXT_W-1:0] hx;
      logic        [EXT_W-1:0] hy;
      logic        [EXT_W-1:0] hz;
      logic        [EXT_W-1:0] rad;
      logic                    box;
   } obj_type;

endpackage

[sv/frustum_cull_test.sv]
// Top level of the six-plane frustum culling block: request register, plane
// units, result register. Depends on frc_pkg, frc_coeff_bank, frc_plane_unit.
//
//  Channel   Direction  Beat carries
//  req_*     in         action, coefficient load or sphere/box query
//  rsp_*     out        inside_res, one beat per sphere or box query
//
// One item per cycle sustained while rsp_ready stays high. A query reaches rsp_valid by
// way of the pipeline registers in order: the accept edge loads the request register,
// then the product registers are loaded, then the result register.
// Coefficient loads are written at their accept edge and give no beat.
// Synchronous active-high reset clears the valid bits only; coefficients are
// undefined until loaded. A stalled rsp_ready backs up stage by stage, so
// req_ready drops only once every stage holds a query.
module frustum_cull_test #(
   parameter int FRAC_BITS = frc_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_action,
   input  logic [frc_pkg::COEFF_IDX_W-1:0]     req_coeff_index,
   input  logic signed [frc_pkg::VAL_W-1:0]    req_coeff_value,
   input  logic signed [frc_pkg::VAL_W-1:0]    req_pos_x,
   input  logic signed [frc_pkg::VAL_W-1:0]    req_pos_y,
   input  logic signed [frc_pkg::VAL_W-1:0]    req_pos_z,
   input  logic [frc_pkg::EXT_W-1:0]           req_sphere_radius,
   input  logic [frc_pkg::EXT_W-1:0]           req_half_x,
   input  logic [frc_pkg::EXT_W-1:0]           req_half_y,
   input  logic [frc_pkg::EXT_W-1:0]           req_half_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_inside_res
);

   frc_pkg::plane_type planes [frc_pkg::NUM_PLANES];
   frc_pkg::obj_type   obj_in, obj_ff;
   logic               accept, is_query, is_load;
   logic               q_valid_in, q_valid_ff;
   logic               p_valid_in, p_valid_ff;
   logic               rsp_valid_in, rsp_valid_ff;
   logic               rsp_inside_res_in, rsp_inside_res_ff;
   logic               en_q, en_p, en_r;
   logic [frc_pkg::NUM_PLANES-1:0] plane_pass;

   // stage enables: a stage moves when empty or when the next one moves
   assign en_r      = ~rsp_valid_ff | rsp_ready;
   assign en_p      = ~p_valid_ff | en_r;
   assign en_q      = ~q_valid_ff | en_p;
   assign req_ready = en_q;
   assign accept    = req_valid & req_ready;

   assign is_load  = (req_action == frc_pkg::ACT_LOAD);
   assign is_query = (req_action == frc_pkg::ACT_SPHERE) || (req_action == frc_pkg::ACT_BOX);

   // coefficient store
   frc_coeff_bank u_coeff_bank (
      .clock    (clock),
      .wr_en    (accept & is_load),
      .wr_idx   (req_coeff_index),
      .wr_value (req_coeff_value),
      .planes   (planes)
   );

   // request register
   always_comb begin
      obj_in.px  = req_pos_x;
      obj_in.py  = req_pos_y;
      obj_in.pz  = req_pos_z;
      obj_in.hx  = req_half_x;
      obj_in.hy  = req_half_y;
      obj_in.hz  = req_half_z;
      obj_in.rad = req_sphere_radius;
      obj_in.box = (req_action == frc_pkg::ACT_BOX);
   end

   assign q_valid_in = en_q ? (accept & is_query) : q_valid_ff;

   always_ff @(posedge clock) begin
      if (accept && is_query) begin
         obj_ff <= obj_in;
      end
   end

   // six planes in parallel
   for (genvar p = 0; p < frc_pkg::NUM_PLANES; p++) begin : g_unit
      frc_plane_unit #(
         .FRAC_BITS (FRAC_BITS)
      ) u_plane_unit (
         .clock   (clock),
         .load_en (en_p & q_valid_ff),
         .coef    (planes[p]),
         .obj     (obj_ff),
         .pass    (plane_pass[p])
      );
   end

   assign p_valid_in = en_p ? q_valid_ff : p_valid_ff;

   // result register
   assign rsp_valid_in      = en_r ? p_valid_ff : rsp_valid_ff;
   assign rsp_inside_res_in = (en_r && p_valid_ff) ? (&plane_pass) : rsp_inside_res_ff;

   always_ff @(posedge clock) begin
      rsp_inside_res_ff <= rsp_inside_res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff   <= 1'b0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         q_valid_ff   <= q_valid_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_res_ff;

endmodule

[sv/frc_coeff_bank.sv]
// Plane coefficient store: 24 registers written one at a time, all read in parallel.
// Depends on frc_pkg.
module frc_coeff_bank (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [frc_pkg::COEFF_IDX_W-1:0]        wr_idx,
   input  logic signed [frc_pkg::VAL_W-1:0]       wr_value,
   output frc_pkg::plane_type                     planes [frc_pkg::NUM_PLANES]
);

   logic signed [frc_pkg::VAL_W-1:0] coeff_ff [frc_pkg::NUM_COEFFS];
   logic                             idx_ok;

   // indexes past the last plane are dropped
   assign idx_ok = (32'(wr_idx) < frc_pkg::NUM_COEFFS);

   always_ff @(posedge clock) begin
      if (wr_en && idx_ok) begin
         coeff_ff[wr_idx] <= wr_value;
      end
   end

   // group the flat store into planes
   for (genvar p = 0; p < frc_pkg::NUM_PLANES; p++) begin : g_plane
      assign planes[p].a = coeff_ff[p*4 + 32'(frc_pkg::COEF_A)];
      assign planes[p].b = coeff_ff[p*4 + 32'(frc_pkg::COEF_B)];
      assign planes[p].c = coeff_ff[p*4 + 32'(frc_pkg::COEF_C)];
      assign planes[p].d = coeff_ff[p*4 + 32'(frc_pkg::COEF_D)];
   end

endmodule

[sv/frc_plane_unit.sv]
// One plane's test: operand adjust and three multiplies into registers, then
// sum and sign check. Depends on frc_pkg.
module frc_plane_unit #(
   parameter int FRAC_BITS = frc_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               load_en,
   input  frc_pkg::plane_type coef,
   input  frc_pkg::obj_type   obj,
   output logic               pass
);

   localparam int PW = frc_pkg::PROD_W;
   localparam int SW = frc_pkg::SUM_W;
   localparam int OW = frc_pkg::OPND_W;

   logic signed [OW-1:0] opnd_x, opnd_y, opnd_z;
   logic signed [PW-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [PW-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [SW-1:0] offset_in, offset_ff;
   logic signed [SW-1:0] sum;

   // Box form: a*x + |a|*h == a*(x + sign(a)*h), so one product per axis
   function automatic logic signed [OW-1:0] adj_opnd(
      input logic signed [frc_pkg::VAL_W-1:0] p,
      input logic        [frc_pkg::EXT_W-1:0] h,
      input logic                             neg,
      input logic                             box
   );
      logic signed [OW-1:0] pe;
      logic signed [OW-1:0] he;
      pe = OW'(p);
      he = $signed({2'b00, h});
      if (!box) begin
         adj_opnd = pe;
      end else if (neg) begin
         adj_opnd = pe - he;
      end else begin
         adj_opnd = pe + he;
      end
   endfunction

   assign opnd_x = adj_opnd(obj.px, obj.hx, coef.a[frc_pkg::VAL_W-1], obj.box);
   assign opnd_y = adj_opnd(obj.py, obj.hy, coef.b[frc_pkg::VAL_W-1], obj.box);
   assign opnd_z = adj_opnd(obj.pz, obj.hz, coef.c[frc_pkg::VAL_W-1], obj.box);

   assign prod_x_in = PW'(coef.a) * PW'(opnd_x);
   assign prod_y_in = PW'(coef.b) * PW'(opnd_y);
   assign prod_z_in = PW'(coef.c) * PW'(opnd_z);

   // scaled offset, plus the radius for the sphere form
   always_comb begin
      offset_in = SW'(coef.d) <<< FRAC_BITS;
      if (!obj.box) begin
         offset_in = offset_in + ($signed(SW'(obj.rad)) <<< FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
         offset_ff <= offset_in;
      end
   end

   // exact sum; inside this plane when non-negative
   assign sum  = SW'(prod_x_ff) + SW'(prod_y_ff) + SW'(prod_z_ff) + offset_ff;
   assign pass = ~sum[SW-1];

endmodule

[tb/frustum_cull_test_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for frustum_cull_test: loads plane sets, streams sphere, point and
// box queries under varied back-pressure and checks every inside flag against a local predictor.
// Depends on frc_pkg and the frustum_cull_test RTL.
module frustum_cull_test_test;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int FRAC = frc_pkg::FRAC_BITS_DEF;
   localparam int ONE = 1 << FRAC;
   localparam int WALL = 10 * ONE;
   localparam logic signed [frc_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [frc_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic [frc_pkg::EXT_W-1:0] EXT_MAX = '1;
   localparam int CYCLE_LIMIT = 100000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 20;

   typedef logic [frc_pkg::EXT_W-1:0]       ext_type;
   typedef logic [frc_pkg::COEFF_IDX_W-1:0] idx_type;

   typedef struct {
      logic [1:0]                       action;
      logic [frc_pkg::COEFF_IDX_W-1:0]  coeff_index;
      logic signed [frc_pkg::VAL_W-1:0] coeff_value;
      logic signed [frc_pkg::VAL_W-1:0] pos_x;
      logic signed [frc_pkg::VAL_W-1:0] pos_y;
      logic signed [frc_pkg::VAL_W-1:0] pos_z;
      logic [frc_pkg::EXT_W-1:0]        sphere_radius;
      logic [frc_pkg::EXT_W-1:0]        half_x;
      logic [frc_pkg::EXT_W-1:0]        half_y;
      logic [frc_pkg::EXT_W-1:0]        half_z;
   } cull_req_type;

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [1:0]                       req_action = frc_pkg::ACT_LOAD;
   logic [frc_pkg::COEFF_IDX_W-1:0]  req_coeff_index = '0;
   logic signed [frc_pkg::VAL_W-1:0] req_coeff_value = '0;
   logic signed [frc_pkg::VAL_W-1:0] req_pos_x = '0;
   logic signed [frc_pkg::VAL_W-1:0] req_pos_y = '0;
   logic signed [frc_pkg::VAL_W-1:0] req_pos_z = '0;
   logic [frc_pkg::EXT_W-1:0]        req_sphere_radius = '0;
   logic [frc_pkg::EXT_W-1:0]        req_half_x = '0;
   logic [frc_pkg::EXT_W-1:0]        req_half_y = '0;
   logic [frc_pkg::EXT_W-1:0]        req_half_z = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_inside_res;

   // predictor state and expected inside flags, oldest first
   logic signed [frc_pkg::VAL_W-1:0] plane_bank [frc_pkg::NUM_COEFFS];
   logic                             inside_expect_q [$];
   cull_req_type                     pending_q [$];
   cull_req_type                     in_flight_item;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int counted_items = 0;
   int mismatch_count = 0;
   int beat_count = 0;
   int cycle_count = 0;

   frustum_cull_test #(.FRAC_BITS(FRAC)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_coeff_index   (req_coeff_index),
      .req_coeff_value   (req_coeff_value),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_sphere_radius (req_sphere_radius),
      .req_half_x        (req_half_x),
      .req_half_y        (req_half_y),
      .req_half_z        (req_half_z),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_inside_res    (rsp_inside_res)
   );

   // Exact plane test: every term widened to 128 bits, so the sign of the sum is exact
   function automatic logic frustum_holds(cull_req_type q, logic box);
      logic signed [127:0] a, b, c, d, x, y, z, r, hx, hy, hz, acc;
      x = 128'(q.pos_x);
      y = 128'(q.pos_y);
      z = 128'(q.pos_z);
      r = 128'(q.sphere_radius);
      hx = 128'(q.half_x);
      hy = 128'(q.half_y);
      hz = 128'(q.half_z);
      for (int p = 0; p < frc_pkg::NUM_PLANES; p++) begin
         a = 128'(plane_bank[p * 4 + int'(frc_pkg::COEF_A)]);
         b = 128'(plane_bank[p * 4 + int'(frc_pkg::COEF_B)]);
         c = 128'(plane_bank[p * 4 + int'(frc_pkg::COEF_C)]);
         d = 128'(plane_bank[p * 4 + int'(frc_pkg::COEF_D)]);
         acc = a * x + b * y + c * z + (d <<< FRAC);
         if (box) begin
            acc = acc + (a < 0 ? -a : a) * hx + (b < 0 ? -b : b) * hy + (c < 0 ? -c : c) * hz;
         end else begin
            acc = acc + (r <<< FRAC);
         end
         if (acc < 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Apply one accepted beat to the predictor
   function automatic void model_accept(cull_req_type q);
      case (q.action)
         frc_pkg::ACT_LOAD: begin
            if (q.coeff_index < frc_pkg::NUM_COEFFS) plane_bank[q.coeff_index] = q.coeff_value;
         end
         frc_pkg::ACT_SPHERE: inside_expect_q.push_back(frustum_holds(q, 1'b0));
         frc_pkg::ACT_BOX:    inside_expect_q.push_back(frustum_holds(q, 1'b1));
         default: ;
      endcase
   endfunction

   function automatic void flag_mismatch(string what, logic want, logic got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t ns: rsp beat %0d %s: expected %b, got %b",
                  $time, beat_count, what, want, got);
   endfunction

   // ---- stimulus helpers ----
   function automatic int rand_span(int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic int coeff_addr(int plane, logic [1:0] slot);
      return plane * 4 + int'(slot);
   endfunction

   // every field random; callers overwrite the ones the action uses
   function automatic cull_req_type random_req();
      cull_req_type q;
      q.action = 2'($urandom());
      q.coeff_index = idx_type'($urandom());
      q.coeff_value = $urandom();
      q.pos_x = $urandom();
      q.pos_y = $urandom();
      q.pos_z = $urandom();
      q.sphere_radius = ext_type'($urandom());
      q.half_x = ext_type'($urandom());
      q.half_y = ext_type'($urandom());
      q.half_z = ext_type'($urandom());
      return q;
   endfunction

   function automatic void push_load(int idx, logic signed [frc_pkg::VAL_W-1:0] value);
      cull_req_type q;
      q = random_req();
      q.action = frc_pkg::ACT_LOAD;
      q.coeff_index = idx_type'(idx);
      q.coeff_value = value;
      pending_q.push_back(q);
   endfunction

   function automatic void push_query(logic [1:0] act, logic signed [frc_pkg::VAL_W-1:0] x,
                                      logic signed [frc_pkg::VAL_W-1:0] y,
                                      logic signed [frc_pkg::VAL_W-1:0] z,
                                      ext_type r, ext_type hx, ext_type hy, ext_type hz);
      cull_req_type q;
      q = random_req();
      q.action = act;
      q.pos_x = x;
      q.pos_y = y;
      q.pos_z = z;
      if (act == frc_pkg::ACT_SPHERE) begin
         q.sphere_radius = r;
      end else begin
         q.half_x = hx;
         q.half_y = hy;
         q.half_z = hz;
      end
      pending_q.push_back(q);
   endfunction

   function automatic void push_plane(int plane, logic signed [frc_pkg::VAL_W-1:0] a,
                                      logic signed [frc_pkg::VAL_W-1:0] b,
                                      logic signed [frc_pkg::VAL_W-1:0] c,
                                      logic signed [frc_pkg::VAL_W-1:0] d);
      push_load(coeff_addr(plane, frc_pkg::COEF_A), a);
      push_load(coeff_addr(plane, frc_pkg::COEF_B), b);
      push_load(coeff_addr(plane, frc_pkg::COEF_C), c);
      push_load(coeff_addr(plane, frc_pkg::COEF_D), d);
   endfunction

   // plausible frustum: unit-scale normals, offsets well clear of the origin
   function automatic void push_random_frustum();
      for (int p = 0; p < frc_pkg::NUM_PLANES; p++)
         push_plane(p, rand_span(ONE), rand_span(ONE), rand_span(ONE),
                    $urandom_range(100 * ONE, 20 * ONE));
      counted_items += frc_pkg::NUM_COEFFS;
   endfunction

   // mostly realistic queries, some full-range ones, stray loads and unused actions
   function automatic void push_random_step();
      int unsigned pick;
      int idx;
      cull_req_type q;
      pick = $urandom_range(99);
      if (pick < 70) begin
         push_query($urandom_range(1) ? frc_pkg::ACT_BOX : frc_pkg::ACT_SPHERE,
                    rand_span(40 * ONE), rand_span(40 * ONE), rand_span(40 * ONE),
                    ($urandom_range(3) == 0) ? '0 : ext_type'($urandom_range(20 * ONE)),
                    ext_type'($urandom_range(15 * ONE)), ext_type'($urandom_range(15 * ONE)),
                    ext_type'($urandom_range(15 * ONE)));
         counted_items++;
      end else if (pick < 82) begin
         q = random_req();
         q.action = pick[0] ? frc_pkg::ACT_BOX : frc_pkg::ACT_SPHERE;
         pending_q.push_back(q);
         counted_items++;
      end else if (pick < 92) begin
         idx = $urandom_range((1 << frc_pkg::COEFF_IDX_W) - 1);
         push_load(idx, pick[0] ? $urandom() : rand_span(ONE));
         if (idx < frc_pkg::NUM_COEFFS) counted_items++;
      end else begin
         q = random_req();
         q.action = ACT_UNUSED;
         pending_q.push_back(q);
      end
   endfunction

   task automatic wait_sent();
      while (pending_q.size() != 0 || req_valid) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || req_valid || inside_expect_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_random(int count, int send_pct, int recv_pct, bit hold);
      int target;
      target = counted_items + count;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      while (counted_items < target) begin
         if ($urandom_range(59) == 0) push_random_frustum();
         push_random_step();
      end
      if (hold) hold_requests++;
      wait_sent();
   endtask

   // ---- clock ----
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---- request driver ----
   always @(posedge clock) begin
      cull_req_type next_item;
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) model_accept(in_flight_item);
         if (!req_valid || req_ready) begin
            offer = pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct;
            if (offer) begin
               next_item = pending_q.pop_front();
               in_flight_item = next_item;
               req_action <= next_item.action;
               req_coeff_index <= next_item.coeff_index;
               req_coeff_value <= next_item.coeff_value;
               req_pos_x <= next_item.pos_x;
               req_pos_y <= next_item.pos_y;
               req_pos_z <= next_item.pos_z;
               req_sphere_radius <= next_item.sphere_radius;
               req_half_x <= next_item.half_x;
               req_half_y <= next_item.half_y;
               req_half_z <= next_item.half_z;
            end
            req_valid <= offer;
         end
      end
   end

   // ---- response ready: random stalls plus the occasional long hold-off ----
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   // ---- response monitor ----
   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (inside_expect_q.size() == 0) begin
            flag_mismatch("with nothing outstanding", 1'bx, rsp_inside_res);
         end else begin
            want = inside_expect_q.pop_front();
            if (rsp_inside_res !== want) flag_mismatch("inside_res", want, rsp_inside_res);
         end
         beat_count++;
      end
   end

   // ---- watchdog ----
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---- sequence ----
   initial begin
      // axis-aligned cube [0,10] on every axis
      push_plane(0,  ONE, 0, 0, 0);
      push_plane(1, -ONE, 0, 0, WALL);
      push_plane(2, 0,  ONE, 0, 0);
      push_plane(3, 0, -ONE, 0, WALL);
      push_plane(4, 0, 0,  ONE, 0);
      push_plane(5, 0, 0, -ONE, WALL);
      // loads past the last plane and unused actions must leave the bank alone
      push_load(frc_pkg::NUM_COEFFS, VAL_MIN);
      push_load((1 << frc_pkg::COEFF_IDX_W) - 1, VAL_MIN);
      begin
         cull_req_type q;
         q = random_req();
         q.action = ACT_UNUSED;
         pending_q.push_back(q);
      end
      // on-plane and one-LSB-off boundaries
      push_query(frc_pkg::ACT_SPHERE, 0, 0, 0, 0, 0, 0, 0);
      push_query(frc_pkg::ACT_SPHERE, -1, 0, 0, 0, 0, 0, 0);
      push_query(frc_pkg::ACT_SPHERE, -1, 0, 0, 1, 0, 0, 0);
      push_query(frc_pkg::ACT_SPHERE, WALL, WALL, WALL, 0, 0, 0, 0);
      push_query(frc_pkg::ACT_SPHERE, WALL + 1, WALL, WALL, 0, 0, 0, 0);
      push_query(frc_pkg::ACT_BOX, -2 * ONE, 5 * ONE, 5 * ONE, 0, ext_type'(2 * ONE), 0, 0);
      push_query(frc_pkg::ACT_BOX, -2 * ONE, 5 * ONE, 5 * ONE, 0, ext_type'(2 * ONE - 1),
                 0, 0);
      // extreme coordinates, radius and half extents
      push_query(frc_pkg::ACT_SPHERE, VAL_MIN, VAL_MIN, VAL_MIN, EXT_MAX, 0, 0, 0);
      push_query(frc_pkg::ACT_BOX, VAL_MAX, VAL_MAX, VAL_MAX, 0, EXT_MAX, EXT_MAX, EXT_MAX);
      push_query(frc_pkg::ACT_BOX, VAL_MIN, VAL_MIN, VAL_MIN, 0, EXT_MAX, EXT_MAX, EXT_MAX);
      // extreme coefficients, then restore the cube
      push_load(coeff_addr(0, frc_pkg::COEF_A), VAL_MIN);
      push_load(coeff_addr(0, frc_pkg::COEF_D), VAL_MAX);
      push_query(frc_pkg::ACT_SPHERE, VAL_MIN, 0, 0, 0, 0, 0, 0);
      push_query(frc_pkg::ACT_BOX, VAL_MAX, ONE, ONE, 0, EXT_MAX, 0, 0);
      push_load(coeff_addr(0, frc_pkg::COEF_A), ONE);
      push_load(coeff_addr(0, frc_pkg::COEF_D), 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      push_random_frustum();
      run_random(200, 0, 0, 1'b0);
      // long receiver hold-off with the sender pushing hard, then a full pause
      run_random(100, 0, 0, 1'b1);
      wait_drained();
      run_random(200, 60, 0, 1'b0);
      run_random(200, 0, 60, 1'b0);
      run_random(200, 30, 30, 1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && inside_expect_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
